/* rtl/ffrsa_pkg.sv */
// Shared constants and codes for the first-fit run slot allocator.
package ffrsa_pkg;

   localparam int POOL_SLOTS = 64;
   localparam int MAX_RUN    = 16;

   localparam int SLOT_W  = $clog2(POOL_SLOTS);
   localparam int LEN_W   = 5;
   localparam int INDEX_W = 7;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

endpackage

/* rtl/first_fit_run_slot_allocator_unit.sv */
// First-fit allocator of contiguous slot runs, with a slot-per-cycle scan sequencer.
//
// The block keeps a pool of 64 slots, each free or in use, and takes one command per
// transaction: allocate a run of 1 to 16 contiguous slots (first fit from slot 0), free one
// slot, query one slot, or clear the whole pool. Every command gives exactly one result
// transaction. An allocate runs through a single shared compare-and-count unit that looks
// at one slot per cycle: the scan walks the pool from slot 0 until a run fits or the last
// slot has been checked, the run found is then marked in use slot by slot, and the result
// is loaded last. An allocate whose run length is refused goes straight to loading its
// result, as do a free, a query and a clear. While a command is being worked on,
// req_stall is high. A finished result sits in an output register, so the next command
// can be accepted while that result still waits for the consumer; a result is only held
// back in its last stage when the output register is still full and stalled. After reset
// every slot is free.
module first_fit_run_slot_allocator_unit
   import ffrsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [LEN_W-1:0]   req_run_length,
   input  logic [INDEX_W-1:0] req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SLOT_W-1:0]  rsp_start_slot,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_in_use
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_MARK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

   logic [1:0]            state_ff,    state_in;
   logic [CMD_W-1:0]      cmd_ff,      cmd_in;
   logic [LEN_W-1:0]      len_ff,      len_in;
   logic [INDEX_W-1:0]    idx_ff,      idx_in;
   logic [SLOT_W-1:0]     ptr_ff,      ptr_in;
   logic [LEN_W-1:0]      cnt_ff,      cnt_in;
   logic [SLOT_W-1:0]     start_ff,    start_in;
   logic [STAT_W-1:0]     status_ff,   status_in;
   logic [POOL_SLOTS-1:0] free_map_ff, free_map_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_start_ff,  rsp_start_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                  rsp_in_use_ff, rsp_in_use_in;

   logic                  req_take;
   logic                  out_free;
   logic                  cur_free;
   logic [LEN_W-1:0]      cnt_next;
   logic                  idx_in_range;
   logic [SLOT_W-1:0]     idx_slot;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // The output register can take a new result when it is empty or being emptied now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The shared unit: one slot of the free map, and the run counter advanced past it.
   assign cur_free  = free_map_ff[ptr_ff];
   assign cnt_next  = cnt_ff + LEN_W'(1);

   assign idx_in_range = (idx_ff < INDEX_W'(POOL_SLOTS));
   assign idx_slot     = idx_ff[SLOT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      status_in     = status_ff;
      free_map_in   = free_map_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      rsp_in_use_in = rsp_in_use_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_command;
               len_in    = req_run_length;
               idx_in    = req_slot_index;
               ptr_in    = '0;
               cnt_in    = '0;
               start_in  = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               if (req_command == CMD_ALLOC) begin
                  // A length of zero or above the longest run never fits.
                  if (req_run_length == '0 || req_run_length > LEN_W'(MAX_RUN)) begin
                     status_in = ST_NO_ROOM;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (cur_free && cnt_next == len_ff) begin
               // The run ends at this slot, so it started len - 1 slots back.
               start_in = ptr_ff - SLOT_W'(len_ff - LEN_W'(1));
               ptr_in   = ptr_ff - SLOT_W'(len_ff - LEN_W'(1));
               cnt_in   = '0;
               state_in = S_MARK;
            end else if (ptr_ff == LAST_SLOT) begin
               status_in = ST_NO_ROOM;
               start_in  = '0;
               state_in  = S_DONE;
            end else begin
               cnt_in = cur_free ? cnt_next : '0;
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end
         S_MARK: begin
            free_map_in[ptr_ff] = 1'b0;
            if (cnt_next == len_ff) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               cnt_in = cnt_next;
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = '0;
               rsp_status_in = ST_OK;
               rsp_in_use_in = 1'b0;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     rsp_start_in  = start_ff;
                     rsp_status_in = status_ff;
                  end
                  CMD_FREE: begin
                     rsp_start_in = idx_slot;
                     if (idx_in_range) begin
                        free_map_in[idx_slot] = 1'b1;
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  CMD_QUERY: begin
                     rsp_start_in = idx_slot;
                     if (idx_in_range) begin
                        rsp_in_use_in = !free_map_ff[idx_slot];
                     end else begin
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     free_map_in = '1;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_map_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_map_ff  <= free_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_in_use_ff <= rsp_in_use_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_start_slot = rsp_start_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_in_use     = rsp_in_use_ff;

   // Every slot that gets marked was seen free by the scan.
   a_mark_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> free_map_ff[ptr_ff])
      else $error("marking a slot that is already in use");

   // The run counter never reaches the requested length while scanning or marking.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_MARK) |-> (cnt_ff < len_ff))
      else $error("run counter overran the run length");

   // Commands other than allocate go straight to the result stage.
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command != CMD_ALLOC) |=> (state_ff == S_DONE))
      else $error("free, query or clear did not go straight to the result stage");

   // A slot in use is only reported together with an ok status.
   a_in_use_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_in_use_ff) |-> (rsp_status_ff == ST_OK))
      else $error("in-use flag reported with an error status");

endmodule

/* verif/tb_first_fit_run_slot_allocator_unit.sv */
// Self-checking testbench for the first-fit run slot allocator unit.
`timescale 1ns / 1ps

// The bench offers allocate, free, query and clear commands to the allocator.
// Every command transaction accepted at the request port is run through a
// model of the 64-slot pool kept inside this module. The model's answer is
// queued, and each result transaction leaving the block is compared field by
// field with the oldest answer in that queue.
//
// Stimulus is built up front: a directed opening that walks the field
// extremes and the special cases (no room, bad run lengths, out-of-range
// slots, freeing a free slot, an exactly full pool), followed by random
// episodes. Each episode usually starts with a clear and then mixes mostly
// allocations with frees and queries, so the pool fills, fragments and runs
// out of room again and again.
module tb_first_fit_run_slot_allocator_unit
   import ffrsa_pkg::*;
;

   typedef struct {
      logic [CMD_W-1:0]   command;
      logic [LEN_W-1:0]   run_length;
      logic [INDEX_W-1:0] slot_index;
   } pool_command_type;

   typedef struct packed {
      logic [SLOT_W-1:0] start_slot;
      logic [STAT_W-1:0] status;
      logic              in_use;
   } slot_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_command = '0;
   logic [LEN_W-1:0]   req_run_length = '0;
   logic [INDEX_W-1:0] req_slot_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [SLOT_W-1:0]  rsp_start_slot;
   logic [STAT_W-1:0]  rsp_status;
   logic               rsp_in_use;

   // Commands still to be offered, and answers still to be seen at the output.
   pool_command_type pending_commands[$];
   slot_reply_type   awaited_replies[$];

   // The model's own copy of the pool: one bit per slot, 1 meaning free.
   logic [POOL_SLOTS-1:0] model_free_slots = '1;

   logic req_taken = 1'b0;
   int   mismatch_count = 0;
   int   commands_taken = 0;
   int   results_seen = 0;

   // The long receiver hold-off is counted down in a process of its own.
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   first_fit_run_slot_allocator_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_run_length (req_run_length),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_start_slot (rsp_start_slot),
      .rsp_status     (rsp_status),
      .rsp_in_use     (rsp_in_use)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input int len, input int idx);
      pool_command_type c;
      c.command    = cmd;
      c.run_length = len[LEN_W-1:0];
      c.slot_index = idx[INDEX_W-1:0];
      pending_commands.push_back(c);
   endtask

   // Applies one command to the model pool and returns the answer the block
   // should give for it. Allocation is first fit: the lowest start at which
   // the whole run is free and lies inside the pool.
   function automatic slot_reply_type apply_pool_command(input pool_command_type c);
      slot_reply_type r;
      int             base;
      int             k;
      int             found_at;
      bit             fits;
      r        = '0;
      found_at = -1;
      case (c.command)
         CMD_ALLOC: begin
            if (c.run_length != 0 && c.run_length <= MAX_RUN) begin
               for (base = 0; base + c.run_length <= POOL_SLOTS && found_at < 0; base++) begin
                  fits = 1'b1;
                  for (k = 0; k < c.run_length; k++)
                     if (!model_free_slots[base + k])
                        fits = 1'b0;
                  if (fits)
                     found_at = base;
               end
            end
            if (found_at < 0) begin
               r.status = ST_NO_ROOM;
            end else begin
               for (k = 0; k < c.run_length; k++)
                  model_free_slots[found_at + k] = 1'b0;
               r.start_slot = found_at[SLOT_W-1:0];
               r.status     = ST_OK;
            end
         end
         CMD_FREE: begin
            r.start_slot = c.slot_index[SLOT_W-1:0];
            if (c.slot_index >= POOL_SLOTS)
               r.status = ST_RANGE;
            else
               model_free_slots[c.slot_index] = 1'b1;
         end
         CMD_QUERY: begin
            r.start_slot = c.slot_index[SLOT_W-1:0];
            if (c.slot_index >= POOL_SLOTS)
               r.status = ST_RANGE;
            else
               r.in_use = !model_free_slots[c.slot_index];
         end
         default: begin
            model_free_slots = '1;
         end
      endcase
      return r;
   endfunction

   // Sender. A payload that has been offered stays put until it is taken.
   // Otherwise the next command goes out, unless this cycle is an idle one.
   // Idling stops during a middle stretch of the run and while the receiver
   // is held off, so that the block fills up and has to stall its input.
   always @(negedge clock) begin : drive_requests
      pool_command_type c;
      bit               idle_now;
      idle_now = ($urandom_range(0, 99) < 37);
      if ((commands_taken >= 600 && commands_taken < 800) || hold_left != 0)
         idle_now = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_commands.size() != 0 && !idle_now) begin
         c = pending_commands.pop_front();
         req_command    <= c.command;
         req_run_length <= c.run_length;
         req_slot_index <= c.slot_index;
         req_valid      <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver stall: the long hold-off wins, then a calm stretch, otherwise random.
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_left != 0)
         rsp_stall <= 1'b1;
      else if (results_seen >= 600 && results_seen < 800)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < 37);
   end

   // Once a few hundred results have gone by, the receiver stops taking
   // anything for a long stretch while the sender keeps offering commands.
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && results_seen >= 250) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor. The result transaction is checked before the command accepted
   // at the same edge is modelled, since a result can only belong to a
   // command that was taken earlier.
   always @(posedge clock) begin : watch_ports
      slot_reply_type   want;
      pool_command_type c;
      if (reset) begin
         model_free_slots = '1;
         awaited_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_replies.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_start_slot, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_start_slot !== want.start_slot)
                  report_mismatch("start_slot", rsp_start_slot, want.start_slot);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_in_use !== want.in_use)
                  report_mismatch("in_use", rsp_in_use, want.in_use);
            end
         end
         if (req_valid && !req_stall) begin
            c.command    = req_command;
            c.run_length = req_run_length;
            c.slot_index = req_slot_index;
            awaited_replies.push_back(apply_pool_command(c));
            commands_taken++;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Stimulus, reset and the end of the run.
   initial begin : stimulus
      int episode_len;
      int pick;
      int len;
      int idx;
      int n;

      // Directed opening: an empty pool, field extremes and the special cases.
      queue_command(CMD_QUERY, 0, 0);
      queue_command(CMD_ALLOC, 1, 127);
      queue_command(CMD_ALLOC, 16, 0);
      queue_command(CMD_QUERY, 31, 16);
      queue_command(CMD_QUERY, 0, 17);
      queue_command(CMD_QUERY, 16, 63);
      queue_command(CMD_QUERY, 0, 64);
      queue_command(CMD_QUERY, 31, 127);
      queue_command(CMD_FREE, 31, 127);
      queue_command(CMD_FREE, 0, 100);
      // Run lengths of zero or above the maximum are refused as no room.
      queue_command(CMD_ALLOC, 0, 5);
      queue_command(CMD_ALLOC, 17, 0);
      queue_command(CMD_ALLOC, 31, 127);
      // Free a slot in use, then free it again while already free.
      queue_command(CMD_FREE, 1, 5);
      queue_command(CMD_FREE, 1, 5);
      queue_command(CMD_ALLOC, 1, 0);
      queue_command(CMD_ALLOC, 2, 0);
      queue_command(CMD_CLEAR, 31, 127);
      // Fill the pool exactly, find it full, then reuse the very last slot.
      queue_command(CMD_ALLOC, 16, 0);
      queue_command(CMD_ALLOC, 16, 0);
      queue_command(CMD_ALLOC, 16, 0);
      queue_command(CMD_ALLOC, 16, 0);
      queue_command(CMD_ALLOC, 1, 0);
      queue_command(CMD_FREE, 0, 63);
      queue_command(CMD_ALLOC, 1, 0);
      queue_command(CMD_QUERY, 0, 63);

      // Random episodes. Fields that a command does not use carry noise.
      while (pending_commands.size() < 1300) begin
         if ($urandom_range(0, 9) < 7)
            queue_command(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 127));
         episode_len = $urandom_range(20, 80);
         for (n = 0; n < episode_len; n++) begin
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127)
                                               : $urandom_range(0, 63);
            if (pick < 50) begin
               len = $urandom_range(0, 99);
               if (len < 80)
                  len = $urandom_range(1, 4);
               else if (len < 95)
                  len = $urandom_range(5, MAX_RUN);
               else if (len < 97)
                  len = 0;
               else
                  len = $urandom_range(MAX_RUN + 1, 31);
               queue_command(CMD_ALLOC, len, $urandom_range(0, 127));
            end else if (pick < 70) begin
               queue_command(CMD_FREE, $urandom_range(0, 31), idx);
            end else if (pick < 95) begin
               queue_command(CMD_QUERY, $urandom_range(0, 31), idx);
            end else begin
               queue_command(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 127));
            end
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait for every command to be taken and every answer to arrive, then
      // give the block more than its longest allocation to show anything extra.
      while (pending_commands.size() != 0 || req_valid)
         @(negedge clock);
      while (awaited_replies.size() != 0)
         @(negedge clock);
      repeat (200) @(negedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch("results never delivered", 0, awaited_replies.size());

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
rtl/ffrsa_pkg.sv
rtl/first_fit_run_slot_allocator_unit.sv
verif/tb_first_fit_run_slot_allocator_unit.sv
